### src/bm25_pkg.sv
// shared types, constants and helpers for the bm25 scoring engine
// no dependencies; used by every module of the block
package bm25_pkg;

  localparam int NUM_DOCS = 4096;
  localparam int TOP_MAX  = 64;
  localparam int DOC_W    = $clog2(NUM_DOCS);
  localparam int CNT_W    = $clog2(NUM_DOCS + 1);
  localparam int RANK_W   = 7;
  localparam int SCORE_W  = 32;
  localparam int LEN_W    = 16;
  localparam int IDF_W    = 21;
  localparam int AVG_W    = 24;
  localparam int K1_W     = 16;
  localparam int B_W      = 13;
  localparam int BL_W     = B_W + LEN_W;
  localparam int NORM_W   = 38;
  localparam int IF_W     = IDF_W + LEN_W;
  localparam int DIVN_W   = 54;
  localparam int DIVD_W   = 42;
  localparam int DCNT_W   = $clog2(DIVN_W);

  localparam logic [B_W-1:0]    ONE_Q12  = B_W'(4096);
  localparam logic [AVG_W-1:0]  ONE_Q8   = AVG_W'(256);
  localparam logic [K1_W:0]     ONE_K1   = (K1_W + 1)'(4096);

  localparam logic [1:0] CFG_AVG  = 2'd0;
  localparam logic [1:0] CFG_HITS = 2'd1;
  localparam logic [1:0] CFG_K1   = 2'd2;
  localparam logic [1:0] CFG_B    = 2'd3;

  typedef enum logic [1:0] {
    OP_SET_LEN   = 2'd0,
    OP_NEW_QUERY = 2'd1,
    OP_POSTING   = 2'd2,
    OP_FINISH    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_LEN,
    ST_P_RD,
    ST_P_MUL,
    ST_P_DIV1,
    ST_P_W1,
    ST_P_KN,
    ST_P_DEN,
    ST_P_DIV2,
    ST_P_W2,
    ST_P_WR,
    ST_Q_RD,
    ST_Q_WR,
    ST_F_SCAN,
    ST_F_DEC
  } state_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_MID,
    EM_LAST,
    EM_NONE
  } emit_t;

  typedef struct packed {
    logic [AVG_W-1:0]  avg_doc_len;
    logic [RANK_W-1:0] max_hits;
    logic [K1_W-1:0]   k1_gain;
    logic [B_W-1:0]    b_norm;
  } cfg_t;

  typedef struct packed {
    logic  ld_item;
    logic  scan_init;
    logic  wr_len;
    logic  post_rd;
    logic  post_mul;
    logic  post_num;
    logic  div_start;
    logic  div_num;
    logic  ld_norm;
    logic  post_kn;
    logic  ld_den;
    logic  post_wr;
    logic  list_rd;
    logic  q_clr;
    logic  q_done;
    logic  clr_step;
    logic  scan_step;
    logic  promote;
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    logic doc_ok;
    logic div_done;
    logic den_zero;
    logic walk_end;
    logic pipe_empty;
    logic clr_last;
    logic found;
    logic rank_zero;
    logic rank_next_full;
    logic k_zero;
    logic out_free;
  } sts_t;

  function automatic logic ranks_before(input logic [SCORE_W-1:0] sa,
                                        input logic [DOC_W-1:0]   da,
                                        input logic [SCORE_W-1:0] sb,
                                        input logic [DOC_W-1:0]   db);
    ranks_before = (sa > sb) || ((sa == sb) && (da < db));
  endfunction

endpackage

### src/bm25_div.sv
// restoring divider, one quotient bit per cycle
// depends on bm25_pkg for operand widths
module bm25_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bm25_pkg::DIVN_W-1:0]  dividend,
  input  logic [bm25_pkg::DIVD_W-1:0]  divisor,
  output logic                         done,
  output logic [bm25_pkg::DIVN_W-1:0]  quot
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [bm25_pkg::DCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [bm25_pkg::DIVN_W-1:0]   quo_r, quo_nxt;
  logic [bm25_pkg::DIVD_W-1:0]   rem_r, rem_nxt;
  logic [bm25_pkg::DIVD_W-1:0]   dvs_r, dvs_nxt;
  logic [bm25_pkg::DIVD_W:0]     rem_sh;
  logic                          fits;

  assign rem_sh = {rem_r, quo_r[bm25_pkg::DIVN_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? bm25_pkg::DIVD_W'(rem_sh - {1'b0, dvs_r})
                     : rem_sh[bm25_pkg::DIVD_W-1:0];
      quo_nxt = {quo_r[bm25_pkg::DIVN_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == bm25_pkg::DCNT_W'(bm25_pkg::DIVN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

### src/bm25_dp.sv
// datapath: length, score and touched-list memories, bm25 arithmetic,
// top-k scan and output register; depends on bm25_pkg and bm25_div
module bm25_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bm25_pkg::cfg_t                cfg,
  input  bm25_pkg::cmd_t                cmd,
  output bm25_pkg::sts_t                sts,
  input  logic [bm25_pkg::DOC_W-1:0]    in_doc,
  input  logic [bm25_pkg::LEN_W-1:0]    in_amount,
  input  logic [bm25_pkg::IDF_W-1:0]    in_idf,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [55:0]                   out_tdata,  // hit_doc, hit_score, hit_rank
  output logic                          out_tuser,  // hit_valid
  output logic                          out_tlast
);

  localparam int DW = bm25_pkg::DOC_W;
  localparam int SW = bm25_pkg::SCORE_W;

  logic [bm25_pkg::LEN_W-1:0]  len_mem   [bm25_pkg::NUM_DOCS];
  logic [SW:0]                 score_mem [bm25_pkg::NUM_DOCS];
  logic [DW-1:0]               list_mem  [bm25_pkg::NUM_DOCS];

  logic [DW-1:0]               doc_r;
  logic [bm25_pkg::LEN_W-1:0]  amt_r;
  logic [bm25_pkg::IDF_W-1:0]  idf_r;
  logic [bm25_pkg::LEN_W-1:0]  len_q;
  logic [SW:0]                 sq;
  logic [DW-1:0]               list_q;

  logic [bm25_pkg::BL_W-1:0]   bl_r;
  logic [bm25_pkg::IF_W-1:0]   if_r;
  logic [bm25_pkg::DIVN_W-1:0] num_r;
  logic [bm25_pkg::NORM_W-1:0] norm_r;
  logic [bm25_pkg::DIVN_W-1:0] kn_r;
  logic [bm25_pkg::DIVD_W-1:0] den_r;

  logic [bm25_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [bm25_pkg::CNT_W-1:0]  walk_r, walk_nxt;
  logic [DW-1:0]               clr_r, clr_nxt;
  logic                        v1_r, v2_r;
  logic [DW-1:0]               d2_r;
  logic                        found_r, found_nxt;
  logic [SW-1:0]               cand_s_r;
  logic [DW-1:0]               cand_d_r;
  logic [SW-1:0]               pend_s_r;
  logic [DW-1:0]               pend_d_r;
  logic [bm25_pkg::RANK_W-1:0] rank_r, rank_nxt;

  logic                        ov_r, ov_nxt;
  logic [DW-1:0]               o_doc_r;
  logic [SW-1:0]               o_score_r;
  logic [bm25_pkg::RANK_W-1:0] o_rank_r;
  logic                        o_valid_r, o_last_r;

  logic [bm25_pkg::AVG_W-1:0]  avg_eff;
  logic [bm25_pkg::B_W-1:0]    b_eff;
  logic [bm25_pkg::RANK_W-1:0] k_eff;
  logic                        div_done;
  logic [bm25_pkg::DIVN_W-1:0] quot;
  logic [bm25_pkg::DIVN_W-1:0] div_a;
  logic [bm25_pkg::DIVD_W-1:0] div_b;
  logic [bm25_pkg::DIVN_W:0]   sum;
  logic [SW-1:0]               sum_sat;
  logic                        s_we;
  logic [DW-1:0]               s_waddr;
  logic [SW:0]                 s_wdata;
  logic                        s_re;
  logic [DW-1:0]               s_raddr;
  logic                        take;
  logic                        append;
  logic                        out_free;

  assign avg_eff = (cfg.avg_doc_len == '0) ? bm25_pkg::ONE_Q8 : cfg.avg_doc_len;
  assign b_eff   = (cfg.b_norm > bm25_pkg::ONE_Q12) ? bm25_pkg::ONE_Q12 : cfg.b_norm;
  assign k_eff   = (cfg.max_hits > bm25_pkg::RANK_W'(bm25_pkg::TOP_MAX))
                   ? bm25_pkg::RANK_W'(bm25_pkg::TOP_MAX) : cfg.max_hits;

  assign div_a = cmd.div_num ? num_r : bm25_pkg::DIVN_W'({bl_r, 8'b0});
  assign div_b = cmd.div_num ? den_r : bm25_pkg::DIVD_W'(avg_eff);

  bm25_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (quot)
  );

  // a zero denominator adds nothing
  assign sum     = (bm25_pkg::DIVN_W + 1)'(sq[SW-1:0])
                 + ((den_r == '0) ? '0 : (bm25_pkg::DIVN_W + 1)'(quot));
  assign sum_sat = (|sum[bm25_pkg::DIVN_W:SW]) ? '1 : sum[SW-1:0];
  assign append  = cmd.post_wr && !sq[SW]
                   && (count_r < bm25_pkg::CNT_W'(bm25_pkg::NUM_DOCS));

  always_comb begin
    s_we    = 1'b0;
    s_waddr = doc_r;
    s_wdata = '0;
    if (cmd.clr_step) begin
      s_we    = 1'b1;
      s_waddr = clr_r;
    end else if (cmd.q_clr) begin
      s_we    = 1'b1;
      s_waddr = list_q;
    end else if (cmd.post_wr) begin
      s_we    = 1'b1;
      s_wdata = {1'b1, sum_sat};
    end
  end

  assign s_re    = v1_r || cmd.post_rd;
  assign s_raddr = v1_r ? list_q : doc_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_len) begin
      len_mem[doc_r] <= amt_r;
    end
    if (cmd.post_rd) begin
      len_q <= len_mem[doc_r];
    end
    if (s_we) begin
      score_mem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      sq <= score_mem[s_raddr];
    end
    if (append) begin
      list_mem[count_r[DW-1:0]] <= doc_r;
    end
    if (cmd.list_rd || cmd.scan_step) begin
      list_q <= list_mem[walk_r[DW-1:0]];
    end
  end

  // stage after the score read of the scan: compare against candidate
  assign take = v2_r && (sq[SW-1:0] != '0)
                && ((rank_r == '0)
                    || bm25_pkg::ranks_before(pend_s_r, pend_d_r, sq[SW-1:0], d2_r))
                && (!found_r
                    || bm25_pkg::ranks_before(sq[SW-1:0], d2_r, cand_s_r, cand_d_r));

  assign out_free = !ov_r || out_tready;

  always_comb begin
    count_nxt = count_r;
    if (cmd.q_done) begin
      count_nxt = '0;
    end else if (append) begin
      count_nxt = count_r + 1'b1;
    end
    walk_nxt = walk_r;
    if (cmd.scan_init) begin
      walk_nxt = '0;
    end else if (cmd.list_rd || cmd.scan_step) begin
      walk_nxt = walk_r + 1'b1;
    end
    clr_nxt   = cmd.clr_step ? clr_r + 1'b1 : clr_r;
    found_nxt = cmd.scan_init ? 1'b0 : (found_r || take);
    rank_nxt  = rank_r;
    if (cmd.ld_item) begin
      rank_nxt = '0;
    end else if (cmd.promote) begin
      rank_nxt = rank_r + 1'b1;
    end
    ov_nxt = ov_r;
    if (cmd.emit != bm25_pkg::EM_IDLE) begin
      ov_nxt = 1'b1;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      walk_r  <= '0;
      clr_r   <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      found_r <= 1'b0;
      rank_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      walk_r  <= walk_nxt;
      clr_r   <= clr_nxt;
      v1_r    <= cmd.scan_step;
      v2_r    <= v1_r;
      found_r <= found_nxt;
      rank_r  <= rank_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      doc_r <= in_doc;
      amt_r <= in_amount;
      idf_r <= in_idf;
    end
    if (cmd.post_mul) begin
      bl_r <= b_eff * len_q;
      if_r <= idf_r * amt_r;
    end
    if (cmd.post_num) begin
      num_r <= bm25_pkg::DIVN_W'(if_r * (bm25_pkg::ONE_K1 + (bm25_pkg::K1_W + 1)'(cfg.k1_gain)));
    end
    if (cmd.ld_norm) begin
      norm_r <= bm25_pkg::NORM_W'(bm25_pkg::ONE_Q12 - b_eff)
              + bm25_pkg::NORM_W'(quot[bm25_pkg::BL_W+7:0]);
    end
    if (cmd.post_kn) begin
      kn_r <= cfg.k1_gain * norm_r;
    end
    if (cmd.ld_den) begin
      den_r <= bm25_pkg::DIVD_W'({amt_r, 12'b0})
             + kn_r[bm25_pkg::DIVN_W-1:12];
    end
    if (v1_r) begin
      d2_r <= list_q;
    end
    if (take) begin
      cand_s_r <= sq[SW-1:0];
      cand_d_r <= d2_r;
    end
    if (cmd.promote) begin
      pend_s_r <= cand_s_r;
      pend_d_r <= cand_d_r;
    end
    case (cmd.emit)
      bm25_pkg::EM_MID, bm25_pkg::EM_LAST: begin
        o_doc_r   <= pend_d_r;
        o_score_r <= pend_s_r;
        o_rank_r  <= rank_r;
        o_valid_r <= 1'b1;
        o_last_r  <= (cmd.emit == bm25_pkg::EM_LAST);
      end
      bm25_pkg::EM_NONE: begin
        o_doc_r   <= '0;
        o_score_r <= '0;
        o_rank_r  <= '0;
        o_valid_r <= 1'b0;
        o_last_r  <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign sts.doc_ok         = {1'b0, doc_r} < (DW + 1)'(bm25_pkg::NUM_DOCS);
  assign sts.div_done       = div_done;
  assign sts.den_zero       = (den_r == '0);
  assign sts.walk_end       = (walk_r == count_r);
  assign sts.pipe_empty     = !v1_r && !v2_r;
  assign sts.clr_last       = (clr_r == DW'(bm25_pkg::NUM_DOCS - 1));
  assign sts.found          = found_r;
  assign sts.rank_zero      = (rank_r == '0);
  assign sts.rank_next_full = ((rank_r + 1'b1) == k_eff);
  assign sts.k_zero         = (k_eff == '0);
  assign sts.out_free       = out_free;

  assign out_tvalid = ov_r;
  assign out_tdata  = {5'b0, o_rank_r, o_score_r, o_doc_r};
  assign out_tuser  = o_valid_r;
  assign out_tlast  = o_last_r;

endmodule

### src/bm25_ctrl.sv
// controller state machine: sequences clearing, length writes, postings, query reset and top-k
// depends on bm25_pkg for state, command and status types
module bm25_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  bm25_pkg::op_t   in_op,
  output logic            in_tready,
  input  bm25_pkg::sts_t  sts,
  output bm25_pkg::cmd_t  cmd
);

  bm25_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bm25_pkg::ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bm25_pkg::ST_CLR: begin
        if (sts.clr_last) state_nxt = bm25_pkg::ST_IDLE;
      end
      bm25_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          case (in_op)
            bm25_pkg::OP_SET_LEN:   state_nxt = bm25_pkg::ST_LEN;
            bm25_pkg::OP_NEW_QUERY: state_nxt = bm25_pkg::ST_Q_RD;
            bm25_pkg::OP_POSTING:   state_nxt = bm25_pkg::ST_P_RD;
            default:                state_nxt = bm25_pkg::ST_F_SCAN;
          endcase
        end
      end
      bm25_pkg::ST_LEN:    state_nxt = bm25_pkg::ST_IDLE;
      bm25_pkg::ST_P_RD:   state_nxt = sts.doc_ok ? bm25_pkg::ST_P_MUL : bm25_pkg::ST_IDLE;
      bm25_pkg::ST_P_MUL:  state_nxt = bm25_pkg::ST_P_DIV1;
      bm25_pkg::ST_P_DIV1: state_nxt = bm25_pkg::ST_P_W1;
      bm25_pkg::ST_P_W1: begin
        if (sts.div_done) state_nxt = bm25_pkg::ST_P_KN;
      end
      bm25_pkg::ST_P_KN:   state_nxt = bm25_pkg::ST_P_DEN;
      bm25_pkg::ST_P_DEN:  state_nxt = bm25_pkg::ST_P_DIV2;
      bm25_pkg::ST_P_DIV2: state_nxt = sts.den_zero ? bm25_pkg::ST_P_WR : bm25_pkg::ST_P_W2;
      bm25_pkg::ST_P_W2: begin
        if (sts.div_done) state_nxt = bm25_pkg::ST_P_WR;
      end
      bm25_pkg::ST_P_WR:   state_nxt = bm25_pkg::ST_IDLE;
      bm25_pkg::ST_Q_RD:   state_nxt = sts.walk_end ? bm25_pkg::ST_IDLE : bm25_pkg::ST_Q_WR;
      bm25_pkg::ST_Q_WR:   state_nxt = bm25_pkg::ST_Q_RD;
      bm25_pkg::ST_F_SCAN: begin
        if (sts.k_zero) begin
          state_nxt = bm25_pkg::ST_F_DEC;
        end else if (sts.walk_end && sts.pipe_empty) begin
          state_nxt = bm25_pkg::ST_F_DEC;
        end
      end
      bm25_pkg::ST_F_DEC: begin
        // no candidate, or a candidate that fills the list, ends the finish
        if (sts.out_free || (sts.found && sts.rank_zero && !sts.k_zero)) begin
          if (sts.k_zero || !sts.found || sts.rank_next_full) begin
            if (!sts.found || sts.k_zero || !sts.rank_zero) begin
              state_nxt = (sts.found && !sts.k_zero) ? bm25_pkg::ST_F_DEC
                                                     : bm25_pkg::ST_IDLE;
            end else begin
              state_nxt = bm25_pkg::ST_F_DEC;
            end
          end else begin
            state_nxt = bm25_pkg::ST_F_SCAN;
          end
        end
      end
      default: state_nxt = bm25_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.emit  = bm25_pkg::EM_IDLE;
    in_tready = 1'b0;
    case (state_r)
      bm25_pkg::ST_CLR:    cmd.clr_step = 1'b1;
      bm25_pkg::ST_IDLE: begin
        in_tready     = 1'b1;
        cmd.ld_item   = in_tvalid;
        cmd.scan_init = in_tvalid;
      end
      bm25_pkg::ST_LEN:    cmd.wr_len = sts.doc_ok;
      bm25_pkg::ST_P_RD:   cmd.post_rd = 1'b1;
      bm25_pkg::ST_P_MUL:  cmd.post_mul = 1'b1;
      bm25_pkg::ST_P_DIV1: begin
        cmd.div_start = 1'b1;
        cmd.post_num  = 1'b1;
      end
      bm25_pkg::ST_P_W1:   cmd.ld_norm = sts.div_done;
      bm25_pkg::ST_P_KN:   cmd.post_kn = 1'b1;
      bm25_pkg::ST_P_DEN:  cmd.ld_den = 1'b1;
      bm25_pkg::ST_P_DIV2: begin
        cmd.div_num   = 1'b1;
        cmd.div_start = !sts.den_zero;
      end
      bm25_pkg::ST_P_W2:   cmd.div_num = 1'b1;
      bm25_pkg::ST_P_WR:   cmd.post_wr = 1'b1;
      bm25_pkg::ST_Q_RD: begin
        cmd.q_done  = sts.walk_end;
        cmd.list_rd = !sts.walk_end;
      end
      bm25_pkg::ST_Q_WR:   cmd.q_clr = 1'b1;
      bm25_pkg::ST_F_SCAN: cmd.scan_step = !sts.walk_end && !sts.k_zero;
      bm25_pkg::ST_F_DEC: begin
        if (sts.k_zero || (!sts.found && sts.rank_zero)) begin
          if (sts.out_free) cmd.emit = bm25_pkg::EM_NONE;
        end else if (!sts.found) begin
          if (sts.out_free) cmd.emit = bm25_pkg::EM_LAST;
        end else if (sts.rank_zero) begin
          // first hit only moves into the pending slot
          cmd.promote   = 1'b1;
          cmd.scan_init = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit      = bm25_pkg::EM_MID;
          cmd.promote   = 1'b1;
          cmd.scan_init = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### src/bm25_score_accumulate_topk_unit.sv
// bm25 scoring engine top level: config register file, controller and datapath
// depends on bm25_pkg, bm25_ctrl, bm25_dp (and bm25_div through it)
// set length writes a doc's length; new query clears the score of each touched doc;
// a posting runs two 54-step passes of the shared divider, the second skipped if den is 0;
// finish rescans the touched docs for each hit, and holds while the output is stalled
// reset runs a clearing pass over all 4096 score memory entries with in_tready low
module bm25_score_accumulate_topk_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // doc_index, amount, term_idf
  input  logic [1:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // hit_doc, hit_score, hit_rank
  output logic        out_tuser,  // hit_valid
  output logic        out_tlast,  // last_hit
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  bm25_pkg::cfg_t cfg_r, cfg_nxt;
  bm25_pkg::cmd_t cmd;
  bm25_pkg::sts_t sts;
  logic           wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_paddr[3:2])
        bm25_pkg::CFG_AVG:  cfg_nxt.avg_doc_len = cfg_pwdata[bm25_pkg::AVG_W-1:0];
        bm25_pkg::CFG_HITS: cfg_nxt.max_hits    = cfg_pwdata[bm25_pkg::RANK_W-1:0];
        bm25_pkg::CFG_K1:   cfg_nxt.k1_gain     = cfg_pwdata[bm25_pkg::K1_W-1:0];
        bm25_pkg::CFG_B:    cfg_nxt.b_norm      = cfg_pwdata[bm25_pkg::B_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.avg_doc_len <= bm25_pkg::AVG_W'(256);
      cfg_r.max_hits    <= bm25_pkg::RANK_W'(10);
      cfg_r.k1_gain     <= bm25_pkg::K1_W'(6144);
      cfg_r.b_norm      <= bm25_pkg::B_W'(3072);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      bm25_pkg::CFG_AVG:  cfg_prdata = 32'(cfg_r.avg_doc_len);
      bm25_pkg::CFG_HITS: cfg_prdata = 32'(cfg_r.max_hits);
      bm25_pkg::CFG_K1:   cfg_prdata = 32'(cfg_r.k1_gain);
      bm25_pkg::CFG_B:    cfg_prdata = 32'(cfg_r.b_norm);
      default:            cfg_prdata = '0;
    endcase
  end

  bm25_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (bm25_pkg::op_t'(in_tuser)),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bm25_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .sts        (sts),
    .in_doc     (in_tdata[11:0]),
    .in_amount  (in_tdata[27:12]),
    .in_idf     (in_tdata[48:28]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
